>>> rtl/aescfb_pkg.sv
// Shared types, tables and round functions for the AES-128 CFB core.
`default_nettype none
package aescfb_pkg;

   localparam int BlockBits  = 128;
   localparam int Rounds     = 10;
   localparam int RkEntries  = Rounds + 1;
   localparam int RkAddrBits = 4;
   localparam int CsrIdxBits = 3;

   // register indexes of the configuration port
   localparam logic [CsrIdxBits-1:0] CSR_KEY_HIGH = 3'd0;
   localparam logic [CsrIdxBits-1:0] CSR_KEY_LOW  = 3'd1;
   localparam logic [CsrIdxBits-1:0] CSR_IV_HIGH  = 3'd2;
   localparam logic [CsrIdxBits-1:0] CSR_IV_LOW   = 3'd3;
   localparam logic [CsrIdxBits-1:0] CSR_DECRYPT  = 3'd4;

   // round key write toward the key memory
   typedef struct packed {
      logic                  we;
      logic [RkAddrBits-1:0] addr;
      logic [BlockBits-1:0]  data;
   } rk_wr_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [Rounds] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at bits [127-8i -: 8]
   function automatic logic [7:0] get_byte(input logic [BlockBits-1:0] v, input int i);
      get_byte = v[BlockBits-1-8*i -: 8];
   endfunction

   // one AES round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey
   function automatic logic [BlockBits-1:0] aes_round(input logic [BlockBits-1:0] s,
                                                       input logic [BlockBits-1:0] rk,
                                                       input logic last);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [BlockBits-1:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            t[4*c+w] = SBOX[get_byte(s, 4*((c+w)%4)+w)];
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[BlockBits-1-8*i -: 8] = t[i];
      end
      aes_round = r ^ rk;
   endfunction

   // next round key from the current one
   function automatic logic [BlockBits-1:0] key_next(input logic [BlockBits-1:0] k,
                                                      input logic [7:0] rc);
      logic [31:0] t, n0, n1, n2, n3;
      t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
      n0 = k[127:96] ^ t;
      n1 = k[95:64] ^ n0;
      n2 = k[63:32] ^ n1;
      n3 = k[31:0] ^ n2;
      key_next = {n0, n1, n2, n3};
   endfunction

endpackage
`default_nettype wire

>>> rtl/aescfb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module aescfb_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 11
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> rtl/aescfb_keyexp.sv
// Key schedule sequencer: writes one round key per cycle into the key memory.
`default_nettype none
module aescfb_keyexp
   import aescfb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [BlockBits-1:0] key,
   output logic                      busy,
   output rk_wr_type                 rk_wr
);

   logic                  busy_ff, busy_in;
   logic [RkAddrBits-1:0] cnt_ff, cnt_in;
   logic [BlockBits-1:0]  rk_ff, rk_in;

   // a start reloads the key; while busy, step one round per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rk_in   = rk_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rk_in   = key;
      end else if (busy_ff) begin
         rk_in = key_next(rk_ff, RCON[cnt_ff < RkAddrBits'(Rounds) ? cnt_ff : '0]);
         if (cnt_ff == RkAddrBits'(Rounds)) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rk_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         rk_ff   <= rk_in;
      end
   end

   assign busy        = busy_ff || start;
   assign rk_wr.we    = busy_ff && !start;
   assign rk_wr.addr  = cnt_ff;
   assign rk_wr.data  = rk_ff;

   wr_addr_range: assert property (@(posedge clock) disable iff (reset)
      rk_wr.we |-> rk_wr.addr <= RkAddrBits'(Rounds))
      else $error("round key write beyond schedule");
   start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && cnt_ff == '0)
      else $error("key schedule did not restart");
   done_stop: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && cnt_ff == RkAddrBits'(Rounds) |=> !busy_ff || $past(start))
      else $error("key schedule ran past last round");

endmodule
`default_nettype wire

>>> rtl/aes128_cfb_cipher_core.sv
// AES-128 full-block CFB core: top level with chaining, round sequencer and output register.
// One 128-bit block per transaction. The block runs one AES round per cycle, reading each
// round key from the key memory: initial key add, ten rounds, then the output load, which
// raises rsp_tvalid. The chaining register feeds the next block, so blocks are processed
// one at a time and the next block is accepted at the earliest in the cycle after the
// output load. A new block is taken while the previous result still waits on rsp; that
// block then holds its output load until the waiting result is taken. After reset the key
// schedule is rebuilt with eleven round key writes, after any write of a key register with
// a key load and eleven round key writes; req_tready is low throughout.
// start flag in req_tuser makes the block start from the IV in place of the chaining register.
`default_nettype none
module aes128_cfb_cipher_core
   import aescfb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [BlockBits-1:0]  req_tdata,  // block_high[63:0], block_low[127:64]
   input  wire logic                  req_tuser,  // start_req
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [BlockBits-1:0]  rsp_tdata,  // out_high[63:0], out_low[127:64]
   input  wire logic                  csr_we,
   input  wire logic [CsrIdxBits-1:0] csr_index,
   input  wire logic [63:0]           csr_wdata
);

   logic [63:0]          key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic                 decrypt_ff;
   logic                 kstart_ff;
   logic [BlockBits-1:0] chain_ff, chain_in;
   logic [BlockBits-1:0] blk_ff, blk_in;
   logic [BlockBits-1:0] st_ff, st_in;
   logic                 run_ff, run_in;
   logic [RkAddrBits-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BlockBits-1:0] rsp_data_ff, rsp_data_in;
   logic [RkAddrBits-1:0] raddr;
   logic [BlockBits-1:0] rk;
   logic [BlockBits-1:0] result;
   logic                 kbusy, accept, finish;
   rk_wr_type            rk_wr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         iv_high_ff  <= '0;
         iv_low_ff   <= '0;
         decrypt_ff  <= 1'b0;
         kstart_ff   <= 1'b0;
      end else begin
         kstart_ff <= csr_we && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW);
         if (csr_we) begin
            unique case (csr_index)
               CSR_KEY_HIGH: key_high_ff <= csr_wdata;
               CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
               CSR_IV_HIGH:  iv_high_ff  <= csr_wdata;
               CSR_IV_LOW:   iv_low_ff   <= csr_wdata;
               CSR_DECRYPT:  decrypt_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   aescfb_keyexp u_keyexp (
      .clock (clock),
      .reset (reset),
      .start (kstart_ff),
      .key   ({key_high_ff, key_low_ff}),
      .busy  (kbusy),
      .rk_wr (rk_wr)
   );

   aescfb_ram #(
      .WIDTH (BlockBits),
      .DEPTH (RkEntries)
   ) u_rk_ram (
      .clock (clock),
      .we    (rk_wr.we),
      .waddr (rk_wr.addr),
      .wdata (rk_wr.data),
      .raddr (raddr),
      .rdata (rk)
   );

   // handshakes
   assign req_tready = !run_ff && !kbusy;
   assign accept     = req_tvalid && req_tready;
   assign finish     = run_ff && cnt_ff == RkAddrBits'(Rounds + 1) &&
                       (!rsp_valid_ff || rsp_tready);
   assign result     = blk_ff ^ st_ff;
   // key address runs one ahead of the round counter
   assign raddr      = (run_ff && cnt_ff < RkAddrBits'(Rounds)) ? cnt_ff + 1'b1 : '0;

   // round sequencer
   always_comb begin
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      st_in        = st_ff;
      blk_in       = blk_ff;
      chain_in     = chain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         run_in = 1'b1;
         cnt_in = '0;
         blk_in = {req_tdata[63:0], req_tdata[127:64]};
         st_in  = req_tuser ? {iv_high_ff, iv_low_ff} : chain_ff;
      end else if (run_ff) begin
         if (cnt_ff == '0) begin
            st_in  = st_ff ^ rk;
            cnt_in = cnt_ff + 1'b1;
         end else if (cnt_ff <= RkAddrBits'(Rounds)) begin
            st_in  = aes_round(st_ff, rk, cnt_ff == RkAddrBits'(Rounds));
            cnt_in = cnt_ff + 1'b1;
         end else if (finish) begin
            run_in       = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
            chain_in     = decrypt_ff ? blk_ff : result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         run_ff       <= run_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff       <= st_in;
      blk_ff      <= blk_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff[63:0], rsp_data_ff[127:64]};

   no_accept_in_keysched: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rk_wr.we && !kstart_ff)
      else $error("block accepted during key schedule");
   accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> run_ff && cnt_ff == '0)
      else $error("accepted block did not start");
   finish_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff && !run_ff)
      else $error("finished block not presented");
   cnt_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> cnt_ff <= RkAddrBits'(Rounds + 1))
      else $error("round counter out of range");

endmodule
`default_nettype wire

>>> sim/tb_aes128_cfb_cipher_core.sv
// Self-checking testbench for the AES-128 full-block CFB core.
`timescale 1ns / 1ps
`default_nettype none
module tb_aes128_cfb_cipher_core;
   import aescfb_pkg::*;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
      logic        start;
   } block_item_type;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } cipher_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BlockBits-1:0]  req_tdata = '0;   // block_high[63:0], block_low[127:64]
   logic                  req_tuser = 1'b0; // start_req
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BlockBits-1:0]  rsp_tdata;        // out_high[63:0], out_low[127:64]
   logic                  csr_we = 1'b0;
   logic [CsrIdxBits-1:0] csr_index = '0;
   logic [63:0]           csr_wdata = '0;

   block_item_type pending_blocks[$];
   cipher_out_type expected_blocks[$];
   block_item_type in_flight;
   int          send_idle_pct = 29;
   int          recv_idle_pct = 56;
   int          rsp_hold_cycles = 0;
   int          fail_count = 0;

   // predictor state
   logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
   logic         decrypt_on;
   logic [127:0] chain_reg;
   logic [127:0] sched [11];

   aes128_cfb_cipher_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4ms;
      $display("aes128_cfb_cipher_core regression: fail");
      $finish;
   end

   function automatic logic [7:0] mul2(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // key schedule as eleven 128-bit round keys
   function automatic void rebuild_schedule();
      logic [31:0] w [44];
      logic [31:0] t;
      w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
      w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0)
            t = {SBOX[t[23:16]] ^ RCON[i/4-1], SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endfunction

   // forward AES-128 on one block, byte 0 in the top bits
   function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ sched[0][127-8*i -: 8];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++) t[4*c+w] = SBOX[s[4*((c+w)%4)+w]];
         if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               x = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ x ^ mul2(a0 ^ a1);
               t[4*c+1] = a1 ^ x ^ mul2(a1 ^ a2);
               t[4*c+2] = a2 ^ x ^ mul2(a2 ^ a3);
               t[4*c+3] = a3 ^ x ^ mul2(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ sched[r][127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) encrypt_block[127-8*i -: 8] = s[i];
   endfunction

   // CFB step: keystream from chain, then feed back the ciphertext side
   function automatic cipher_out_type cfb_step(input block_item_type b);
      logic [127:0]   res;
      cipher_out_type o;
      if (b.start) chain_reg = {iv_hi, iv_lo};
      res = {b.hi, b.lo} ^ encrypt_block(chain_reg);
      chain_reg = decrypt_on ? {b.hi, b.lo} : res;
      o.hi = res[127:64];
      o.lo = res[63:0];
      return o;
   endfunction

   // driver: offer queued blocks, predict on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_blocks = {expected_blocks, cfb_step(in_flight)};
         if (!req_tvalid || req_tready) begin
            if (pending_blocks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = pending_blocks.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {in_flight.lo, in_flight.hi};
               req_tuser  <= in_flight.start;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: random backpressure, compare each result transaction
   always @(posedge clock) begin
      cipher_out_type exp_out;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_blocks.size() == 0) begin
            $error("unexpected result transaction %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_out = expected_blocks.pop_front();
            if (rsp_tdata[63:0] !== exp_out.hi) begin
               $error("out_high expected %h actual %h", exp_out.hi, rsp_tdata[63:0]);
               fail_count++;
            end
            if (rsp_tdata[127:64] !== exp_out.lo) begin
               $error("out_low expected %h actual %h", exp_out.lo, rsp_tdata[127:64]);
               fail_count++;
            end
         end
      end
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic start);
      block_item_type b;
      b.hi = hi; b.lo = lo; b.start = start;
      pending_blocks = {pending_blocks, b};
   endtask

   // wait for all traffic to drain, then let the core settle
   task automatic drain();
      while (pending_blocks.size() > 0 || req_tvalid || expected_blocks.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxBits-1:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_KEY_HIGH: begin key_hi = data; rebuild_schedule(); end
         CSR_KEY_LOW:  begin key_lo = data; rebuild_schedule(); end
         CSR_IV_HIGH:  iv_hi = data;
         CSR_IV_LOW:   iv_lo = data;
         CSR_DECRYPT:  decrypt_on = data[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] pick64();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   initial begin
      key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
      decrypt_on = 1'b0; chain_reg = '0;
      rebuild_schedule();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset state: no start yet, chain is zero; zero key schedule
      queue_block('0, '0, 1'b0);
      queue_block('1, '1, 1'b0);
      queue_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
      queue_block('0, '1, 1'b0);
      drain();

      // all-ones key and IV, decrypt mode
      csr_write(CSR_KEY_HIGH, '1);
      csr_write(CSR_KEY_LOW, '1);
      csr_write(CSR_IV_HIGH, '1);
      csr_write(CSR_IV_LOW, '1);
      csr_write(CSR_DECRYPT, 64'd1);
      queue_block('1, '0, 1'b1);
      queue_block('0, '0, 1'b0);
      queue_block('1, '1, 1'b0);
      queue_block(rand64(), rand64(), 1'b1);
      drain();

      // IV written without a start keeps the chain; indexes past the list are ignored
      csr_write(CSR_IV_HIGH, 64'h8000000000000001);
      csr_write(CSR_IV_LOW, 64'h0000000000000000);
      csr_write(3'd5, '1);
      csr_write(3'd6, rand64());
      csr_write(3'd7, '1);
      queue_block(rand64(), rand64(), 1'b0);
      queue_block(rand64(), rand64(), 1'b1);
      drain();

      // mode flipped mid-stream, chain untouched
      csr_write(CSR_DECRYPT, 64'd0);
      queue_block(rand64(), rand64(), 1'b0);
      queue_block('0, '0, 1'b0);
      drain();

      // random phases with changing keys, IVs and modes
      for (int ph = 0; ph < 14; ph++) begin
         if (ph < 5) begin
            send_idle_pct = 29; recv_idle_pct = 56;
         end else if (ph < 10) begin
            send_idle_pct = 56; recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         if ($urandom_range(2) != 0) csr_write(CSR_KEY_HIGH, pick64());
         if ($urandom_range(2) != 0) csr_write(CSR_KEY_LOW, pick64());
         csr_write(CSR_IV_HIGH, pick64());
         csr_write(CSR_IV_LOW, pick64());
         if ($urandom_range(1) != 0) csr_write(CSR_DECRYPT, {63'd0, 1'($urandom_range(1))});
         if ($urandom_range(5) == 0)
            csr_write(CSR_DECRYPT + 3'(1 + $urandom_range(2)), rand64());
         // a long receiver stall so the core fills and stalls its input
         if (ph == 3 || ph == 11) rsp_hold_cycles = 300;
         for (int k = 0; k < 50; k++)
            queue_block(pick64(), pick64(), (k == 0) || ($urandom_range(7) == 0));
         drain();
      end

      if (fail_count == 0 && expected_blocks.size() == 0) begin
         $display("aes128_cfb_cipher_core regression: pass");
      end else begin
         $display("aes128_cfb_cipher_core regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
